// File: hw/rtl/mbss_pkg.sv
// Package for the band-limited step synthesizer: step table, types, codes and helpers.
package mbss_pkg;

	localparam int TABLE_LEN = 256;
	localparam int TAB_AW    = $clog2(TABLE_LEN);

	localparam logic CMD_STEP   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic        [63:0] bits_tab_t [TABLE_LEN];
	typedef logic signed [31:0] q_tab_t    [TABLE_LEN];

	// pipeline status toward the sequencer
	typedef struct packed {
		logic busy;
		logic rd_en;
		logic wr_en;
	} pipe_stat_t;

	localparam bits_tab_t BLEP_BITS = '{
		64'h3FF000320C7E95A6, 64'h3FF00049BE220FD5, 64'h3FF0001B92A41ACA, 64'h3FEFFF4425AA9724,
		64'h3FEFFDABDF6CF05C, 64'h3FEFFB5AF233EF1A, 64'h3FEFF837E2AE85F3, 64'h3FEFF4217B80E938,
		64'h3FEFEEECEB4E0444, 64'h3FEFE863A8358B5F, 64'h3FEFE04126292670, 64'h3FEFD63072A0D592,
		64'h3FEFC9C9CD36F56F, 64'h3FEFBA90594BD8C3, 64'h3FEFA7F008BA9F13, 64'h3FEF913BE2A0E0E2,
		64'h3FEF75ACCB01A327, 64'h3FEF5460F06A4E8F, 64'h3FEF2C5C0389BD3C, 64'h3FEEFC8859BF6BCB,
		64'h3FEEC3B916FD8D19, 64'h3FEE80AD74F0AD16, 64'h3FEE32153552E2C7, 64'h3FEDD69643CB9778,
		64'h3FED6CD380FFA864, 64'h3FECF374A4D2961A, 64'h3FEC692F19B34E54, 64'h3FEBCCCFA695DD5C,
		64'h3FEB1D44B168764A, 64'h3FEA59A8D8E4527F, 64'h3FE9814D9B10A9A3, 64'h3FE893C5B62135F2,
		64'h3FE790EEEBF9DABD, 64'h3FE678FACDEE27FF, 64'h3FE54C763699791A, 64'h3FE40C4F1B1EB7A3,
		64'h3FE2B9D863D4E0F3, 64'h3FE156CB86586B0B, 64'h3FDFCA8F5005B828, 64'h3FDCCF9C3F455DAC,
		64'h3FD9C2787F20D06E, 64'h3FD6A984CAD0F3E5, 64'h3FD38BB0C452732E, 64'h3FD0705EC7135366,
		64'h3FCABE86754E238F, 64'h3FC4C0801A6E9A04, 64'h3FBDECF490C5EA17, 64'h3FB2DFFACE9CE44B,
		64'h3FA0EFD4449F4620, 64'hBF72F4A65E22806D, 64'hBFA3F872D761F927, 64'hBFB1D89F0FD31F7C,
		64'hBFB8B1EA652EC270, 64'hBFBE79B82A37C92D, 64'hBFC1931B697E685E, 64'hBFC359383D4C8ADA,
		64'hBFC48F3BFF81B06B, 64'hBFC537BBA8D6B15C, 64'hBFC557CEF2168326, 64'hBFC4F6F781B3347A,
		64'hBFC41EF872F0E009, 64'hBFC2DB9F119D54D3, 64'hBFC13A7E196CB44F, 64'hBFBE953A67843504,
		64'hBFBA383D9C597E74, 64'hBFB57FBD67AD55D6, 64'hBFB08E18234E5CB3, 64'hBFA70B06D699FFD1,
		64'hBF9A1CFB65370184, 64'hBF7B2CEB901D2067, 64'h3F86D5DE2C267C78, 64'h3F9C1D9EF73F384D,
		64'h3FA579C530950503, 64'h3FABD1E5FFF9B1D0, 64'h3FB07DCDC3A4FB5B, 64'h3FB2724A856EEC1B,
		64'h3FB3C1F7199FC822, 64'h3FB46D0979F5043B, 64'h3FB47831387E0110, 64'h3FB3EC4A58A3D527,
		64'h3FB2D5F45F8889B3, 64'h3FB145113E25B749, 64'h3FAE9860D18779BC, 64'h3FA9FFD5F5AB96EA,
		64'h3FA4EC6C4F47777E, 64'h3F9F16C5B2604C3A, 64'h3F9413D801124DB7, 64'h3F824F668CBB5BDF,
		64'hBF55B3FA2EE30D66, 64'hBF86541863B38183, 64'hBF94031BBBD551DE, 64'hBF9BAFC27DC5E769,
		64'hBFA102B3683C57EC, 64'hBFA3731E608CC6E4, 64'hBFA520C9F5B5DEBD, 64'hBFA609DC89BE6ECE,
		64'hBFA632B83BC5F52F, 64'hBFA5A58885841AD4, 64'hBFA471A5D2FF02F3, 64'hBFA2AAD5CD0377C7,
		64'hBFA0686FFE4B9B05, 64'hBF9B88DE413ACB69, 64'hBF95B4EF6D93F1C5, 64'hBF8F1B72860B27FA,
		64'hBF8296A865CDF612, 64'hBF691BEEDABE928B, 64'h3F65C04E6AF9D4F1, 64'h3F8035D8FFCDB0F8,
		64'h3F89BED23C431BE3, 64'h3F90E737811A1D21, 64'h3F941C2040BD7CB1, 64'h3F967046EC629A09,
		64'h3F97DE27ECE9ED89, 64'h3F98684DE31E7040, 64'h3F9818C4B07718FA, 64'h3F97005261F91F60,
		64'h3F95357FDD157646, 64'h3F92D37C696C572A, 64'h3F8FF1CFF2BEECB5, 64'h3F898D20C7A72AC4,
		64'h3F82BC5B3B0AE2DF, 64'h3F7784A1B8E9E667, 64'h3F637BB14081726B, 64'hBF4B2DACA70C60A9,
		64'hBF6EFB00AD083727, 64'hBF7A313758DC6AE9, 64'hBF819D6A99164BE0, 64'hBF8533F57533403B,
		64'hBF87CD120DB5D340, 64'hBF89638549CD25DE, 64'hBF89FB8B8D37B1BB, 64'hBF89A21163F9204E,
		64'hBF886BA8931297D4, 64'hBF8673477783D71E, 64'hBF83D8E1CB165DB8, 64'hBF80BFEA7216142A,
		64'hBF7A9B9BC2E40EBF, 64'hBF7350E806435A7E, 64'hBF67D35D3734AB5E, 64'hBF52ADE8FEAB8DB9,
		64'h3F415669446478E4, 64'h3F60C56A092AFB48, 64'h3F6B9F4334A4561F, 64'h3F724FB908FD87AA,
		64'h3F75CC56DFE382EA, 64'h3F783A0C23969A7B, 64'h3F799833C40C3B82, 64'h3F79F02721981BF3,
		64'h3F7954212AB35261, 64'h3F77DDE0C5FC15C9, 64'h3F75AD1C98FE0777, 64'h3F72E5DACC0849F2,
		64'h3F6F5D7E69DFDE1B, 64'h3F685EC2CA09E1FD, 64'h3F611D750E54DF3A, 64'h3F53C6E392A46D17,
		64'h3F37A046885F3365, 64'hBF3BB034D2EE45C2, 64'hBF5254267B04B482, 64'hBF5C0516F9CECDC6,
		64'hBF61E5736853564D, 64'hBF64C464B9CC47AB, 64'hBF669C1AEF258F56, 64'hBF67739985DD0E60,
		64'hBF675AFD6446395B, 64'hBF666A0C909B4F78, 64'hBF64BE9879A7A07B, 64'hBF627AC74B119DBD,
		64'hBF5F86B04069DC9B, 64'hBF597BE8F754AF5E, 64'hBF531F3EAAE9A1B1, 64'hBF496D3DE6AD7EA3,
		64'hBF3A05FFDE4670CF, 64'hBF06DF95C93A85CA, 64'h3F31EE2B2C6547AC, 64'h3F41E694A378C129,
		64'h3F4930BF840E23C9, 64'h3F4EBB5D05A0D47D, 64'h3F51404DA0539855, 64'h3F524698F56B3F33,
		64'h3F527EF85309E28F, 64'h3F51FE70FE2513DE, 64'h3F50DF1642009B74, 64'h3F4E7CDA93517CAE,
		64'h3F4A77AE24F9A533, 64'h3F45EE226AA69E10, 64'h3F411DB747374F52, 64'h3F387F39D229D97F,
		64'h3F2E1B3D39AF5F8B, 64'h3F18F557BB082715, 64'hBEFAC04896E68DDB, 64'hBF20F5BC77DF558A,
		64'hBF2C1B6DF3EE94A4, 64'hBF3254602A816876, 64'hBF354E90F6EAC26B, 64'hBF3709F2E5AF1624,
		64'hBF379FCCB331CE8E, 64'hBF37327192ADDAD3, 64'hBF35EA998A894237, 64'hBF33F4C4977B3489,
		64'hBF317EC5F68E887B, 64'hBF2D6B1F793EB773, 64'hBF2786A226B076D9, 64'hBF219BE6CEC2CA36,
		64'hBF17D7F36D2A3A18, 64'hBF0AAEC5BBAB42AB, 64'hBEF01818DC224040, 64'h3EEF2F6E21093846,
		64'h3F049D6E0060B71F, 64'h3F0E598CCAFABEFD, 64'h3F128BC14BE97261, 64'h3F148703BC70EF6A,
		64'h3F1545E1579CAA25, 64'h3F14F7DDF5F8D766, 64'h3F13D10FF9A1BE0C, 64'h3F1206D5738ECE3A,
		64'h3F0F99F6BF17C5D4, 64'h3F0AA6D7EA524E96, 64'h3F0588DDF740E1F4, 64'h3F0086FB6FEA9839,
		64'h3EF7B28F6D6F5EED, 64'h3EEEA300DCBAF74A, 64'h3EE03F904789777C, 64'h3EC1BFEB320501ED,
		64'hBEC310D8E585A031, 64'hBED6F55ECA7E151F, 64'hBEDFDAA5DACDD0B7, 64'hBEE26944F3CF6E90,
		64'hBEE346894453BD1F, 64'hBEE2E099305CD5A8, 64'hBEE190385A7EA8B2, 64'hBEDF4D5FA2FB6BA2,
		64'hBEDAD4F371257BA0, 64'hBED62A9CDEB0AB32, 64'hBED1A6DF97B88316, 64'hBECB100096894E58,
		64'hBEC3E8A76257D275, 64'hBEBBF6C29A5150C9, 64'hBEB296292998088E, 64'hBEA70A10498F0E5E,
		64'hBE99E52D02F887A1, 64'hBE88C17F4066D432, 64'hBE702A716CFF56CA, 64'h3E409F820F781F78,
		64'h3E643EA99B770FE7, 64'h3E67DE40CDE0A550, 64'h3E64F4D534A2335C, 64'h3E5F194536BDDF7A,
		64'h3E5425CEBE1FA40A, 64'h3E46D7B7CC631E73, 64'h3E364746B6582E54, 64'h3E21FC07B13031DE,
		64'h3E064C3D91CF7665, 64'h3DE224F901A0AFC7, 64'h3DA97D57859C74A4, 64'h0000000000000000
	};

	// IEEE double pattern to Q2.30, round half away from zero, saturating
	function automatic logic signed [31:0] to_q230(input logic [63:0] b);
		int          e;
		int          sh;
		logic [63:0] m;
		logic [63:0] mag;
		logic [31:0] mag32;
		e = int'(b[62:52]);
		m = {11'd0, 1'b1, b[51:0]};
		mag = 64'd0;
		if (e == 0) begin
			return 32'sd0;
		end
		if (e == 2047 || e >= 1045) begin
			mag = 64'h7FFF_FFFF;
		end else begin
			sh = 1045 - e;
			if (sh >= 60) begin
				mag = 64'd0;
			end else begin
				mag = (m + (64'd1 << (sh - 1))) >> sh;
			end
			if (mag > 64'h7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
			end
		end
		mag32 = mag[31:0];
		return b[63] ? $signed(-mag32) : $signed(mag32);
	endfunction

	function automatic q_tab_t build_blep();
		q_tab_t t;
		for (int k = 0; k < TABLE_LEN; k++) begin
			t[k] = to_q230(BLEP_BITS[k]);
		end
		return t;
	endfunction

	localparam q_tab_t BLEP_Q = build_blep();

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -35'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// File: hw/rtl/mbss_ring.sv
// Correction ring: synchronous memory with per-entry valid bits, registered read.
module mbss_ring import mbss_pkg::*; #(
	parameter int TAPS = 16,
	localparam int AW = $clog2(TAPS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [AW-1:0]        rd_addr,
	output logic signed [31:0]   rd_data,
	input  logic                 wr_en,
	input  logic [AW-1:0]        wr_addr,
	input  logic signed [31:0]   wr_data
);

	logic signed [31:0] mem [TAPS];
	logic [TAPS-1:0]    valid_q;
	logic signed [31:0] rd_word_q;
	logic               rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : 32'sd0;

endmodule

// File: hw/rtl/mbss_tap_pipe.sv
// Tap pipeline: walks the taps of a step, interpolates the table and scales by amplitude.
module mbss_tap_pipe import mbss_pkg::*; #(
	parameter int TAPS = 16,
	parameter int OVERSAMPLE = 16,
	localparam int AW = $clog2(TAPS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          step_offset,
	input  logic signed [31:0]   step_amplitude,
	input  logic [AW-1:0]        start_addr,
	output pipe_stat_t           stat,
	output logic [AW-1:0]        rd_addr,
	output logic [AW-1:0]        wr_addr,
	output logic signed [33:0]   add_value
);

	localparam int IDX_W0 = $clog2(OVERSAMPLE * TAPS + 1);
	localparam int IDX_W  = (IDX_W0 > TAB_AW + 1) ? IDX_W0 : TAB_AW + 1;
	localparam int P_W    = 16 + $clog2(OVERSAMPLE + 1);
	localparam int CNT_W  = $clog2(TAPS);

	function automatic logic signed [31:0] tab_at(input logic [IDX_W-1:0] i);
		if (i < IDX_W'(TABLE_LEN)) begin
			return BLEP_Q[i[TAB_AW-1:0]];
		end
		return 32'sd0;
	endfunction

	logic [P_W-1:0]      pos_prod;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    idx_nx;
	logic [AW-1:0]       addr_q;
	logic [CNT_W-1:0]    n_q;
	logic                run_q;
	logic [15:0]         frac_q;
	logic signed [31:0]  amp_q;
	logic signed [31:0]  t0;
	logic signed [31:0]  t1;

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic [AW-1:0]       addr_s1, addr_s2, addr_s3, addr_s4;
	logic signed [31:0]  t0_s1, t0_s2;
	logic signed [32:0]  diff_s1;
	logic signed [49:0]  prod_s2;
	logic signed [33:0]  interp;
	logic signed [31:0]  v;
	logic signed [63:0]  mul_s3;
	logic signed [33:0]  add_s4;

	assign pos_prod = P_W'(step_offset) * P_W'(OVERSAMPLE);
	assign idx_nx   = IDX_W'(idx_q + IDX_W'(1));
	assign t0       = tab_at(idx_q);
	assign t1       = tab_at(idx_nx);
	assign interp   = {{2{t0_s2[31]}}, t0_s2} + 34'(prod_s2 >>> 16);
	assign v        = interp[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			n_q    <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				n_q   <= '0;
			end else if (run_q) begin
				n_q <= CNT_W'(n_q + CNT_W'(1));
				if (n_q == CNT_W'(TAPS - 1)) begin
					run_q <= 1'b0;
				end
			end
			vld_s1 <= run_q;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			idx_q  <= IDX_W'(pos_prod[P_W-1:16]);
			frac_q <= pos_prod[15:0];
			amp_q  <= step_amplitude;
			addr_q <= start_addr;
		end else if (run_q) begin
			idx_q  <= IDX_W'(idx_q + IDX_W'(OVERSAMPLE));
			addr_q <= (addr_q == AW'(TAPS - 1)) ? '0 : AW'(addr_q + AW'(1));
		end
		t0_s1   <= t0;
		diff_s1 <= {t1[31], t1} - {t0[31], t0};
		addr_s1 <= addr_q;
		prod_s2 <= diff_s1 * $signed({1'b0, frac_q});
		t0_s2   <= t0_s1;
		addr_s2 <= addr_s1;
		mul_s3  <= amp_q * v;
		addr_s3 <= addr_s2;
		add_s4  <= 34'((mul_s3 + 64'sd536870912) >>> 30);
		addr_s4 <= addr_s3;
	end

	assign stat.busy  = run_q | vld_s1 | vld_s2 | vld_s3 | vld_s4;
	assign stat.rd_en = vld_s3;
	assign stat.wr_en = vld_s4;
	assign rd_addr    = addr_s3;
	assign wr_addr    = addr_s4;
	assign add_value  = add_s4;

endmodule

// File: hw/rtl/minblep_step_synthesizer_core.sv
// Top level of the band-limited step synthesizer: sequencer, ring and tap pipeline.
//
//  channel | direction | handshake           | payload
//  input   | in        | in_valid / in_stall | command, step_offset, step_amplitude, input_sample
//  output  | out       | out_valid/out_stall | output_sample, tail_remaining
//
// During a step request the tap pipeline updates one ring entry per cycle, reading and
// writing back the ring memory; the sequencer also waits through the pipeline's fill and drain.
// A sample request does one ring read, then the sum, clear and output load.
// Reset clears the ring through per-entry valid bits; no clearing pass is needed.
// A sample waits in its final cycle while the output register is full and stalled.
module minblep_step_synthesizer_core import mbss_pkg::*; #(
	parameter int TAPS = 16,
	parameter int OVERSAMPLE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 command,
	input  logic [15:0]          step_offset,
	input  logic signed [31:0]   step_amplitude,
	input  logic signed [31:0]   input_sample,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   output_sample,
	output logic [4:0]           tail_remaining
);

	localparam int AW = $clog2(TAPS);
	localparam logic [4:0] TAIL_INIT = (TAPS > 31) ? 5'd31 : 5'(TAPS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_SAMP = 2'd2;

	logic [1:0]          state_q;
	logic [AW-1:0]       pos_q;
	logic [4:0]          tail_q;
	logic signed [31:0]  sample_q;
	logic                out_valid_q;
	logic signed [31:0]  out_sample_q;
	logic [4:0]          out_tail_q;

	logic                accept;
	logic                samp_start;
	logic                step_start;
	logic                samp_fin;
	logic [4:0]          tail_nx;

	pipe_stat_t          pstat;
	logic [AW-1:0]       p_rd_addr;
	logic [AW-1:0]       p_wr_addr;
	logic signed [33:0]  p_add;

	logic                ring_rd_en;
	logic [AW-1:0]       ring_rd_addr;
	logic signed [31:0]  ring_rd_data;
	logic                ring_wr_en;
	logic [AW-1:0]       ring_wr_addr;
	logic signed [31:0]  ring_wr_data;
	logic signed [34:0]  step_sum;
	logic signed [34:0]  samp_sum;

	assign in_stall   = (state_q != ST_IDLE);
	assign accept     = in_valid & ~in_stall;
	assign samp_start = accept & (command == CMD_SAMPLE);
	assign step_start = accept & (command == CMD_STEP);
	assign samp_fin   = (state_q == ST_SAMP) & (~out_valid_q | ~out_stall);
	assign tail_nx    = (tail_q != 5'd0) ? 5'(tail_q - 5'd1) : 5'd0;

	mbss_tap_pipe #(
		.TAPS       (TAPS),
		.OVERSAMPLE (OVERSAMPLE)
	) u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (step_start),
		.step_offset    (step_offset),
		.step_amplitude (step_amplitude),
		.start_addr     (pos_q),
		.stat           (pstat),
		.rd_addr        (p_rd_addr),
		.wr_addr        (p_wr_addr),
		.add_value      (p_add)
	);

	assign step_sum = {{3{ring_rd_data[31]}}, ring_rd_data} + {p_add[33], p_add};
	assign samp_sum = {{3{ring_rd_data[31]}}, ring_rd_data}
		+ {{3{sample_q[31]}}, sample_q};

	assign ring_rd_en   = samp_start | pstat.rd_en;
	assign ring_rd_addr = samp_start ? pos_q : p_rd_addr;
	assign ring_wr_en   = pstat.wr_en | samp_fin;
	assign ring_wr_addr = samp_fin ? pos_q : p_wr_addr;
	assign ring_wr_data = samp_fin ? 32'sd0 : sat32(step_sum);

	mbss_ring #(
		.TAPS (TAPS)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ring_rd_en),
		.rd_addr (ring_rd_addr),
		.rd_data (ring_rd_data),
		.wr_en   (ring_wr_en),
		.wr_addr (ring_wr_addr),
		.wr_data (ring_wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			tail_q      <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (step_start) begin
						state_q <= ST_STEP;
						tail_q  <= TAIL_INIT;
					end else if (samp_start) begin
						state_q <= ST_SAMP;
					end
				end
				ST_STEP: begin
					if (!pstat.busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SAMP: begin
					if (samp_fin) begin
						state_q <= ST_IDLE;
						tail_q  <= tail_nx;
						pos_q   <= (pos_q == AW'(TAPS - 1)) ? '0 : AW'(pos_q + AW'(1));
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (samp_fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samp_start) begin
			sample_q <= input_sample;
		end
		if (samp_fin) begin
			out_sample_q <= sat32(samp_sum);
			out_tail_q   <= tail_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign output_sample  = out_sample_q;
	assign tail_remaining = out_tail_q;

	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pstat.wr_en && samp_fin))
		else $error("ring write from both step and sample paths");

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		pstat.busy |-> in_stall)
		else $error("input taken while tap pipeline busy");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		samp_fin |=> out_valid)
		else $error("finished sample not presented");

	a_tail_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tail_remaining < TAIL_INIT))
		else $error("tail count out of range");

	a_step_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) && !out_valid |=> !out_valid)
		else $error("step request produced a result");

endmodule

// File: dv/minblep_step_synthesizer_checker.sv
// Checker for the band-limited step synthesizer: predicts sample results and compares them.
`timescale 1ns / 1ps
module minblep_step_synthesizer_checker import mbss_pkg::*; #(
	parameter int TAPS = 16,
	parameter int OVERSAMPLE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 command,
	input  logic [15:0]          step_offset,
	input  logic signed [31:0]   step_amplitude,
	input  logic signed [31:0]   input_sample,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic signed [31:0]   output_sample,
	input  logic [4:0]           tail_remaining,
	output int                   fail_count,
	output int                   pending
);

	typedef struct packed {
		logic signed [31:0] sample;
		logic [4:0]         tail;
	} sample_result_t;

	longint             blep_tab [TABLE_LEN];
	logic signed [31:0] corr_ring [TAPS];
	int                 read_pos;
	int                 tail_left;
	sample_result_t     sample_results_q [$];

	function automatic longint double_to_q230(input logic [63:0] d);
		int          expo;
		int          shift;
		logic [63:0] mant;
		longint      mag;
		expo = int'(d[62:52]);
		if (expo == 0) begin
			return 0;
		end
		mant = {11'd0, 1'b1, d[51:0]};
		shift = 1045 - expo;
		if (expo == 2047 || shift <= 0) begin
			mag = 64'h7FFF_FFFF;
		end else if (shift >= 60) begin
			mag = 0;
		end else begin
			mag = longint'((mant + (64'd1 << (shift - 1))) >> shift);
			if (mag > 64'sh7FFF_FFFF) begin
				mag = 64'h7FFF_FFFF;
			end
		end
		return d[63] ? -mag : mag;
	endfunction

	function automatic longint blep_at(input longint idx);
		return (idx >= TABLE_LEN) ? 0 : blep_tab[idx];
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	task automatic insert_step(input logic [15:0] off, input logic signed [31:0] amp);
		longint phase;
		longint base;
		longint frac;
		longint t0;
		longint t1;
		longint interp;
		longint add;
		int     slot;
		phase = longint'(off) * OVERSAMPLE;
		base = phase >> 16;
		frac = phase & 64'hFFFF;
		slot = read_pos;
		for (int n = 0; n < TAPS; n++) begin
			t0 = blep_at(base + n * OVERSAMPLE);
			t1 = blep_at(base + n * OVERSAMPLE + 1);
			interp = t0 + (((t1 - t0) * frac) >>> 16);
			add = (longint'(amp) * interp + (64'sd1 <<< 29)) >>> 30;
			corr_ring[slot] = clip32(longint'(corr_ring[slot]) + add);
			slot = (slot + 1) % TAPS;
		end
		tail_left = (TAPS > 31) ? 31 : TAPS;
	endtask

	function automatic sample_result_t correct_sample(input logic signed [31:0] smp);
		sample_result_t r;
		r.sample = clip32(longint'(smp) + longint'(corr_ring[read_pos]));
		corr_ring[read_pos] = '0;
		read_pos = (read_pos + 1) % TAPS;
		if (tail_left > 0) begin
			tail_left--;
		end
		r.tail = tail_left[4:0];
		return r;
	endfunction

	initial begin
		for (int k = 0; k < TABLE_LEN; k++) begin
			blep_tab[k] = double_to_q230(BLEP_BITS[k]);
		end
	end

	always @(posedge clk) begin
		sample_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				corr_ring[k] = '0;
			end
			read_pos = 0;
			tail_left = 0;
			fail_count = 0;
			pending = 0;
			sample_results_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (sample_results_q.size() == 0) begin
					$error("unexpected result: output_sample %0d, tail_remaining %0d",
						output_sample, tail_remaining);
					fail_count++;
				end else begin
					want = sample_results_q.pop_front();
					if (output_sample !== want.sample) begin
						$error("output_sample: expected %0d, actual %0d", want.sample,
							output_sample);
						fail_count++;
					end
					if (tail_remaining !== want.tail) begin
						$error("tail_remaining: expected %0d, actual %0d", want.tail,
							tail_remaining);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (command == CMD_SAMPLE) begin
					sample_results_q.push_back(correct_sample(input_sample));
				end else begin
					insert_step(step_offset, step_amplitude);
				end
			end
			pending = sample_results_q.size();
		end
	end

endmodule

// File: dv/minblep_step_synthesizer_core_test.sv
// Testbench top for the band-limited step synthesizer: request stimulus, output stalls, verdict.
`timescale 1ns / 1ps
module minblep_step_synthesizer_core_test;
	import mbss_pkg::*;

	localparam int TAPS = 16;
	localparam int OVERSAMPLE = 16;
	localparam int RANDOM_ITEMS = 1450;
	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               command;
	logic [15:0]        step_offset;
	logic signed [31:0] step_amplitude;
	logic signed [31:0] input_sample;
	logic               out_valid;
	logic               out_stall;
	logic signed [31:0] output_sample;
	logic [4:0]         tail_remaining;

	int fail_count;
	int pending;
	int items_sent;
	int rx_wait;
	bit tx_gaps_on;
	bit rx_gaps_on;

	always #10 clk = ~clk;

	minblep_step_synthesizer_core #(
		.TAPS(TAPS),
		.OVERSAMPLE(OVERSAMPLE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.step_offset(step_offset),
		.step_amplitude(step_amplitude),
		.input_sample(input_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.output_sample(output_sample),
		.tail_remaining(tail_remaining)
	);

	minblep_step_synthesizer_checker #(
		.TAPS(TAPS),
		.OVERSAMPLE(OVERSAMPLE)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.step_offset(step_offset),
		.step_amplitude(step_amplitude),
		.input_sample(input_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.output_sample(output_sample),
		.tail_remaining(tail_remaining),
		.fail_count(fail_count),
		.pending(pending)
	);

	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return Q_MAX;
			1: return Q_MIN;
			2: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] pick_offset();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	task automatic send_request(input logic cmd, input logic [15:0] off,
			input logic signed [31:0] amp, input logic signed [31:0] smp);
		int unsigned gap;
		gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		step_offset <= off;
		step_amplitude <= amp;
		input_sample <= smp;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// receiver: after each accepted result, stall for a drawn number of cycles
	initial begin
		out_stall <= 1'b0;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				rx_wait = rx_gaps_on ? $urandom_range(0, 9) : 0;
				out_stall <= (rx_wait != 0);
			end else if (rx_wait != 0) begin
				rx_wait--;
				out_stall <= (rx_wait != 0);
			end
		end
	end

	initial begin
		#10_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int nsteps;
		int nsamp;
		int next_drain;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_STEP;
		step_offset <= '0;
		step_amplitude <= '0;
		input_sample <= '0;
		items_sent = 0;
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tail already exhausted, ring empty
		send_request(CMD_SAMPLE, 16'h0000, Q_MAX, 32'sd0);
		send_request(CMD_SAMPLE, 16'hFFFF, Q_MIN, Q_MIN);
		// volume step, then steps that saturate the accumulators
		send_request(CMD_STEP, 16'h0000, Q_MAX, Q_MAX);
		send_request(CMD_STEP, 16'hFFFF, Q_MAX, Q_MIN);
		send_request(CMD_SAMPLE, 16'h1234, 32'sd0, Q_MAX);
		send_request(CMD_STEP, 16'h8000, Q_MIN, 32'sd0);
		send_request(CMD_STEP, 16'hFFFF, Q_MIN, 32'sd0);
		send_request(CMD_STEP, 16'h0001, -32'sd1, 32'sd0);
		send_request(CMD_SAMPLE, 16'h0000, 32'sd0, Q_MIN);
		// run the tail out and wrap the ring
		for (int k = 0; k < 16; k++) begin
			case (k % 4)
				0: send_request(CMD_SAMPLE, pick_offset(), pick_word(), 32'sd0);
				1: send_request(CMD_SAMPLE, pick_offset(), pick_word(), Q_MAX);
				2: send_request(CMD_SAMPLE, pick_offset(), pick_word(), Q_MIN);
				default: send_request(CMD_SAMPLE, pick_offset(), pick_word(), pick_word());
			endcase
		end
		drain_results();

		items_sent = 0;
		next_drain = 300;
		while (items_sent < RANDOM_ITEMS) begin
			tx_gaps_on = ($urandom_range(0, 3) != 0);
			rx_gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0) begin
				send_request($urandom_range(0, 1) ? CMD_SAMPLE : CMD_STEP, pick_offset(),
					pick_word(), pick_word());
			end else begin
				nsteps = $urandom_range(1, 3);
				nsamp = $urandom_range(1, 24);
				repeat (nsteps) send_request(CMD_STEP, pick_offset(), pick_word(), pick_word());
				repeat (nsamp) send_request(CMD_SAMPLE, pick_offset(), pick_word(), pick_word());
			end
			if (items_sent >= next_drain) begin
				drain_results();
				next_drain += 300;
			end
		end

		drain_results();
		repeat (TAPS + 10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
